### hw/rtl/bqss_pkg.sv
`default_nettype none

package bqss_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int COEF_WIDTH    = 16;
  localparam int SHIFT_WIDTH   = 5;
  localparam int CFG_IDX_WIDTH = 3;

  typedef logic signed [DATA_WIDTH-1:0]  data_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic        [SHIFT_WIDTH-1:0] shift_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_NUM_COEF0      = 3'd0,
    REG_NUM_COEF1      = 3'd1,
    REG_NUM_COEF2      = 3'd2,
    REG_DEN_COEF1      = 3'd3,
    REG_DEN_COEF2      = 3'd4,
    REG_FEEDBACK_SHIFT = 3'd5,
    REG_OUTPUT_SHIFT   = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    KIND_FILTER = 1'b0,
    KIND_FLUSH  = 1'b1
  } kind_t;

  // Product of a sample and a coefficient, wrapped to the sample width.
  function automatic data_t mul_wrap(input data_t x, input coef_t c);
    logic signed [DATA_WIDTH+COEF_WIDTH-1:0] p;
    begin
      p = x * c;
      return p[DATA_WIDTH-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/biquad_iir_filter_shift_scaled.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  in_kind, in_sample_in
// out_     output     out_valid / out_stall out_sample_out
// cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A word is captured in the input register; once the result register is free or
// being emptied, the full multiply-accumulate and both shifts of a filter word run
// into the result register. One word per cycle while out_stall is low; the five
// multipliers and the adder tree in the feedback loop set that rate.
// Reset (rst_n low, synchronous) empties both registers, clears the delays and
// restores the default coefficients. While a result waits the input register can
// still take one word; a filter word there raises in_stall in the same cycle as
// out_stall, and a flush word passes even while out_stall is high.
`default_nettype none

module biquad_iir_filter_shift_scaled
  import bqss_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,

  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_kind,
  input  wire logic signed [DATA_WIDTH-1:0] in_sample_in,

  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_WIDTH-1:0]  out_sample_out,

  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [COEF_WIDTH-1:0]    cfg_data
);

  // Configuration registers.
  coef_t  num_coef0_r, num_coef1_r, num_coef2_r;
  coef_t  den_coef1_r, den_coef2_r;
  shift_t feedback_shift_r, output_shift_r;

  // Input register.
  logic   in_v_r;
  kind_t  kind_r;
  data_t  x_r;

  // Delay line.
  data_t  in_d1_r, in_d2_r, fb_d1_r, fb_d2_r;

  // Result register.
  logic   out_v_r;
  data_t  out_data_r;

  logic   go;
  logic   out_take;
  data_t  acc;
  data_t  fb_nxt;
  data_t  out_data_nxt;

  assign cfg_ready      = 1'b1;
  assign out_valid      = out_v_r;
  assign out_sample_out = out_data_r;
  assign out_take       = out_v_r && !out_stall;

  // A flush word leaves no result, so it never waits on the output side.
  assign go       = in_v_r && (kind_r == KIND_FLUSH || !out_v_r || !out_stall);
  assign in_stall = in_v_r && !go;

  always_comb begin
    acc = mul_wrap(x_r, num_coef0_r)
        + mul_wrap(in_d1_r, num_coef1_r)
        + mul_wrap(in_d2_r, num_coef2_r)
        - mul_wrap(fb_d1_r, den_coef1_r)
        - mul_wrap(fb_d2_r, den_coef2_r);
    fb_nxt       = acc >>> feedback_shift_r;
    out_data_nxt = acc >>> output_shift_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_coef0_r      <= coef_t'(1);
      num_coef1_r      <= '0;
      num_coef2_r      <= '0;
      den_coef1_r      <= '0;
      den_coef2_r      <= '0;
      feedback_shift_r <= '0;
      output_shift_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        REG_NUM_COEF0:      num_coef0_r      <= cfg_data;
        REG_NUM_COEF1:      num_coef1_r      <= cfg_data;
        REG_NUM_COEF2:      num_coef2_r      <= cfg_data;
        REG_DEN_COEF1:      den_coef1_r      <= cfg_data;
        REG_DEN_COEF2:      den_coef2_r      <= cfg_data;
        REG_FEEDBACK_SHIFT: feedback_shift_r <= cfg_data[SHIFT_WIDTH-1:0];
        REG_OUTPUT_SHIFT:   output_shift_r   <= cfg_data[SHIFT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_v_r <= 1'b1;
    end else if (go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_r <= kind_t'(in_kind);
      x_r    <= in_sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_d1_r <= '0;
      in_d2_r <= '0;
      fb_d1_r <= '0;
      fb_d2_r <= '0;
    end else if (go) begin
      if (kind_r == KIND_FLUSH) begin
        in_d1_r <= '0;
        in_d2_r <= '0;
        fb_d1_r <= '0;
        fb_d2_r <= '0;
      end else begin
        in_d1_r <= x_r;
        in_d2_r <= in_d1_r;
        fb_d1_r <= fb_nxt;
        fb_d2_r <= fb_d1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (go && kind_r == KIND_FILTER) begin
      out_v_r <= 1'b1;
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && kind_r == KIND_FILTER) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_v_r && out_v_r && out_stall && kind_r == KIND_FILTER))
    else $error("input stalled without a blocked result");

  a_flush_clears_delays: assert property (@(posedge clk) disable iff (!rst_n)
    (go && kind_r == KIND_FLUSH) |=>
      (in_d1_r == '0 && in_d2_r == '0 && fb_d1_r == '0 && fb_d2_r == '0))
    else $error("flush did not clear the delay line");

  a_filter_shifts_delays: assert property (@(posedge clk) disable iff (!rst_n)
    (go && kind_r == KIND_FILTER) |=>
      (in_d2_r == $past(in_d1_r) && fb_d2_r == $past(fb_d1_r) && in_d1_r == $past(x_r)))
    else $error("filter word did not advance the delay line");

  a_result_from_filter: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(go && kind_r == KIND_FILTER))
    else $error("result appeared without a filter word");

  a_flush_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (go && kind_r == KIND_FLUSH && !out_v_r) |=> !out_v_r)
    else $error("flush word produced a result");
`endif

endmodule

`default_nettype wire

### test/tb_biquad_iir_filter_shift_scaled.sv
`default_nettype none

module tb_biquad_iir_filter_shift_scaled;
  import bqss_pkg::*;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_PHASES = 10;
  localparam int WORDS_PER_PHASE = 193;

  typedef struct {
    kind_t kind;
    data_t sample;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  logic signed [DATA_WIDTH-1:0] in_sample_in = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DATA_WIDTH-1:0] out_sample_out;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [COEF_WIDTH-1:0] cfg_data = '0;

  biquad_iir_filter_shift_scaled dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_kind,
    .in_sample_in,
    .out_valid,
    .out_stall,
    .out_sample_out,
    .cfg_valid,
    .cfg_ready,
    .cfg_index,
    .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Coefficient and shift settings as the filter should currently hold them.
  coef_t b0 = 16'sd1, b1 = '0, b2 = '0, a1 = '0, a2 = '0;
  shift_t fb_shift = '0, res_shift = '0;

  // Delay line of the filter being modeled.
  data_t x_d1 = '0, x_d2 = '0, y_d1 = '0, y_d2 = '0;

  word_t stim_q[$];
  data_t filtered_q[$];

  bit calm = 1'b0;
  bit in_fire = 1'b0, out_fire = 1'b0, cfg_fire = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int mismatches = 0;
  int words_sent = 0, flushes_sent = 0, results_checked = 0;
  int reg_writes = 0, settings_used = 0;

  function automatic bit biquad_step(input word_t w, output data_t y);
    longint acc64;
    data_t acc;
    begin
      y = '0;
      if (w.kind == KIND_FLUSH) begin
        x_d1 = '0;
        x_d2 = '0;
        y_d1 = '0;
        y_d2 = '0;
        return 1'b0;
      end
      acc64 = longint'(b0) * longint'(w.sample) + longint'(b1) * longint'(x_d1)
            + longint'(b2) * longint'(x_d2) - longint'(a1) * longint'(y_d1)
            - longint'(a2) * longint'(y_d2);
      acc = data_t'(acc64);
      x_d2 = x_d1;
      x_d1 = w.sample;
      y_d2 = y_d1;
      y_d1 = acc >>> fb_shift;
      y = acc >>> res_shift;
      return 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what);
    begin
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    end
  endtask

  // Handshakes are sampled at the rising edge; the word accepted there is
  // run through the model at once so expectations stay in acceptance order.
  always @(posedge clk) begin
    data_t y;
    word_t w;
    in_fire <= rst_n && in_valid && !in_stall;
    out_fire <= rst_n && out_valid && !out_stall;
    cfg_fire <= rst_n && cfg_valid && cfg_ready;
    if (rst_n && in_valid && !in_stall) begin
      w.kind = kind_t'(in_kind);
      w.sample = in_sample_in;
      if (biquad_step(w, y))
        filtered_q.push_back(y);
    end
  end

  always @(posedge clk) begin
    data_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word, sample_out %0d", out_sample_out));
      end else begin
        want = filtered_q.pop_front();
        results_checked++;
        if (out_sample_out !== want)
          report_mismatch($sformatf("sample_out %0d, expected %0d", out_sample_out, want));
      end
    end
  end

  // Input driver.
  always @(negedge clk) begin
    logic nxt_valid;
    word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_fire)
        nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          w = stim_q.pop_front();
          in_kind <= w.kind;
          in_sample_in <= w.sample;
          nxt_valid = 1'b1;
          gap_left = calm ? 0 : $urandom_range(0, 7);
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Result side back-pressure, one draw per accepted result.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_fire)
        stall_left = calm ? 0 : $urandom_range(0, 7);
      out_stall <= (stall_left != 0);
      if (stall_left != 0)
        stall_left--;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [COEF_WIDTH-1:0] val);
    begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= val;
      do @(negedge clk); while (!cfg_fire);
      cfg_valid <= 1'b0;
      reg_writes++;
      case (idx)
        REG_NUM_COEF0: b0 = coef_t'(val);
        REG_NUM_COEF1: b1 = coef_t'(val);
        REG_NUM_COEF2: b2 = coef_t'(val);
        REG_DEN_COEF1: a1 = coef_t'(val);
        REG_DEN_COEF2: a2 = coef_t'(val);
        REG_FEEDBACK_SHIFT: fb_shift = val[SHIFT_WIDTH-1:0];
        REG_OUTPUT_SHIFT: res_shift = val[SHIFT_WIDTH-1:0];
        default: ;
      endcase
    end
  endtask

  task automatic load_setting(input coef_t c0, input coef_t c1, input coef_t c2,
                              input coef_t d1, input coef_t d2,
                              input shift_t fs, input shift_t os);
    begin
      write_reg(REG_NUM_COEF0, c0);
      write_reg(REG_NUM_COEF1, c1);
      write_reg(REG_NUM_COEF2, c2);
      write_reg(REG_DEN_COEF1, d1);
      write_reg(REG_DEN_COEF2, d2);
      // Upper data bits are random; only the low five bits should count.
      write_reg(REG_FEEDBACK_SHIFT, {11'($urandom), fs});
      write_reg(REG_OUTPUT_SHIFT, {11'($urandom), os});
      settings_used++;
    end
  endtask

  // Waits until every word is sent and every expected result is checked, then lets
  // a trailing flush word leave the input register.
  task automatic drain();
    begin
      while (stim_q.size() != 0 || in_valid || filtered_q.size() != 0)
        @(posedge clk);
      repeat (4) @(posedge clk);
    end
  endtask

  task automatic queue_word(input kind_t k, input data_t s);
    word_t w;
    begin
      w.kind = k;
      w.sample = s;
      stim_q.push_back(w);
      words_sent++;
      if (k == KIND_FLUSH)
        flushes_sent++;
    end
  endtask

  function automatic data_t pick_sample();
    begin
      case ($urandom_range(0, 7))
        0: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
        1: return {1'b0, {(DATA_WIDTH-1){1'b1}}};
        2: return data_t'($urandom_range(0, 511)) - 256;
        3: return data_t'($urandom_range(0, 2)) - 1;
        default: return data_t'($urandom);
      endcase
    end
  endfunction

  function automatic coef_t pick_coef();
    begin
      case ($urandom_range(0, 5))
        0: return -16'sd32768;
        1: return 16'sd32767;
        2: return coef_t'($urandom_range(0, 64)) - 16'sd32;
        default: return coef_t'($urandom);
      endcase
    end
  endfunction

  function automatic shift_t pick_shift();
    begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return '1;
        default: return shift_t'($urandom_range(0, 31));
      endcase
    end
  endfunction

  localparam data_t S_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t S_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset coefficients pass the input straight through.
    settings_used = 1;
    queue_word(KIND_FILTER, '0);
    queue_word(KIND_FILTER, 1);
    queue_word(KIND_FILTER, -1);
    queue_word(KIND_FILTER, S_MAX);
    queue_word(KIND_FILTER, S_MIN);
    queue_word(KIND_FILTER, 32'h5555_5555);
    queue_word(KIND_FLUSH, data_t'($urandom));
    queue_word(KIND_FILTER, 32'hAAAA_AAAA);
    drain();

    // Extreme coefficients, including the most negative denominator, which
    // is outside the nominal range, and the largest output shift.
    load_setting(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                 '0, '1);
    write_reg(REG_UNUSED, 16'hFFFF);
    queue_word(KIND_FILTER, S_MAX);
    queue_word(KIND_FILTER, S_MIN);
    queue_word(KIND_FILTER, S_MAX);
    queue_word(KIND_FILTER, -1);
    queue_word(KIND_FLUSH, S_MIN);
    queue_word(KIND_FILTER, S_MIN);
    queue_word(KIND_FILTER, S_MIN);
    queue_word(KIND_FILTER, 1);
    drain();

    load_setting(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32767, 16'sd32767,
                 '1, '0);
    queue_word(KIND_FILTER, S_MIN);
    queue_word(KIND_FILTER, S_MAX);
    queue_word(KIND_FILTER, S_MIN);
    queue_word(KIND_FILTER, S_MAX);
    queue_word(KIND_FLUSH, S_MAX);
    queue_word(KIND_FILTER, -1);
    queue_word(KIND_FILTER, S_MAX);
    queue_word(KIND_FILTER, '0);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_setting(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                   pick_shift(), pick_shift());
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_UNUSED, 16'($urandom));
      calm = (ph % 3 == 2);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if ($urandom_range(0, 11) == 0)
          queue_word(KIND_FLUSH, data_t'($urandom));
        else
          queue_word(KIND_FILTER, pick_sample());
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d words (%0d flushes) under %0d filter settings, %0d register writes;",
             words_sent, flushes_sent, settings_used, reg_writes);
    $display("checked %0d filtered samples, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d words and %0d results outstanding",
             stim_q.size(), filtered_q.size());
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
